// ===== hdl/lat_pkg.sv =====
package lat_pkg;

  // table and pool geometry
  localparam int TABLE_ENTRIES = 32;
  localparam int MAX_POOL      = 256;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int PIDX_W        = $clog2(MAX_POOL + 1);
  localparam int EFF_W         = (PIDX_W > 9) ? PIDX_W : 9;

  // field widths
  localparam int MAC_W   = 48;
  localparam int IP_W    = 32;
  localparam int TIME_W  = 32;
  localparam int TOUT_W  = 13;
  localparam int PSIZE_W = 9;
  localparam int LIM_W   = 33;
  localparam int MB_W    = MAC_W + TIME_W;

  // time constants
  localparam logic [LIM_W-1:0]  US_PER_SECOND   = LIM_W'(1000000);
  localparam logic [TOUT_W-1:0] DEFAULT_TIMEOUT = TOUT_W'(360);

  // commands
  localparam logic [2:0] CMD_DISCOVER = 3'd0;
  localparam logic [2:0] CMD_REQUEST  = 3'd1;
  localparam logic [2:0] CMD_RELEASE  = 3'd2;
  localparam logic [2:0] CMD_ARP      = 3'd3;
  localparam logic [2:0] CMD_AGE      = 3'd4;
  localparam logic [2:0] CMD_RESOLVE  = 3'd5;

  // entry status codes
  localparam logic [1:0] ST_FREE     = 2'd0;
  localparam logic [1:0] ST_RESERVED = 2'd1;
  localparam logic [1:0] ST_VALID    = 2'd2;
  localparam logic [1:0] ST_STALE    = 2'd3;

  // answer codes
  localparam logic [1:0] ANS_NONE    = 2'd0;
  localparam logic [1:0] ANS_GRANT   = 2'd1;
  localparam logic [1:0] ANS_OFFER   = 2'd2;

  // register indexes
  localparam logic [2:0] REG_POOL_START = 3'd0;
  localparam logic [2:0] REG_POOL_SIZE  = 3'd1;
  localparam logic [2:0] REG_MODEM      = 3'd2;
  localparam logic [2:0] REG_TIMEOUT    = 3'd3;
  localparam logic [2:0] REG_SERVER     = 3'd4;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [MAC_W-1:0]  src_mac;
    logic [IP_W-1:0]   ip_addr;
    logic [IP_W-1:0]   target_addr;
    logic [TIME_W-1:0] now_us;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       answer;
    logic [IP_W-1:0]  offered_ip;
    logic [MAC_W-1:0] resolved_mac;
    logic             arp_query_needed;
    logic             flush_pending;
  } out_item_t;

  // configuration seen by the engine
  typedef struct packed {
    logic [IP_W-1:0]   pool_start;
    logic [EFF_W-1:0]  eff_size;
    logic [IP_W-1:0]   modem_address;
    logic              server_mode;
    logic [LIM_W-1:0]  lim_full;
    logic [LIM_W-1:0]  lim_half;
  } cfg_t;

endpackage

// ===== hdl/lat_ram.sv =====
module lat_ram #(
  parameter int W = 32,
  parameter int D = 32
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem_r [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ===== hdl/lat_cfg.sv =====
module lat_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output lat_pkg::cfg_t      cfg
);
  import lat_pkg::*;

  logic [IP_W-1:0]    pool_start_r;
  logic [PSIZE_W-1:0] pool_size_r;
  logic [IP_W-1:0]    modem_r;
  logic [TOUT_W-1:0]  timeout_r;
  logic               server_r;
  logic [LIM_W-1:0]   lim_full_r;
  logic [LIM_W-1:0]   lim_half_r;
  logic [2:0]         reg_idx;
  logic               wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_start_r <= '0;
      pool_size_r  <= '0;
      modem_r      <= '0;
      timeout_r    <= DEFAULT_TIMEOUT;
      server_r     <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_POOL_START: pool_start_r <= pwdata;
        REG_POOL_SIZE:  pool_size_r  <= pwdata[PSIZE_W-1:0];
        REG_MODEM:      modem_r      <= pwdata;
        REG_TIMEOUT:    timeout_r    <= pwdata[TOUT_W-1:0];
        REG_SERVER:     server_r     <= pwdata[0];
        default: ;
      endcase
    end
  end

  // age limits in microseconds: full and half timeout
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_full_r <= LIM_W'(DEFAULT_TIMEOUT) * US_PER_SECOND;
      lim_half_r <= LIM_W'(DEFAULT_TIMEOUT >> 1) * US_PER_SECOND;
    end else begin
      lim_full_r <= LIM_W'(timeout_r) * US_PER_SECOND;
      lim_half_r <= LIM_W'(timeout_r >> 1) * US_PER_SECOND;
    end
  end

  // readback
  always_comb begin
    unique case (reg_idx)
      REG_POOL_START: prdata = pool_start_r;
      REG_POOL_SIZE:  prdata = 32'(pool_size_r);
      REG_MODEM:      prdata = modem_r;
      REG_TIMEOUT:    prdata = 32'(timeout_r);
      REG_SERVER:     prdata = 32'(server_r);
      default:        prdata = '0;
    endcase
  end

  always_comb begin
    cfg.pool_start    = pool_start_r;
    cfg.eff_size      = (EFF_W'(pool_size_r) > EFF_W'(MAX_POOL)) ? EFF_W'(MAX_POOL)
                                                                 : EFF_W'(pool_size_r);
    cfg.modem_address = modem_r;
    cfg.server_mode   = server_r;
    cfg.lim_full      = lim_full_r;
    cfg.lim_half      = lim_half_r;
  end

endmodule

// ===== hdl/lease_and_arp_table_engine_top.sv =====
// Lease and ARP table engine. Pulse start with a command while busy is low; the
// command is taken at that edge and busy stays high until its single result is
// shown on out_item for one cycle with out_valid. The receiver cannot stall:
// sample out_item whenever out_valid is high. Every command sweeps the 32-entry
// table through the address/IP and MAC/stamp memories, one entry per cycle, and
// then decides; a discover that must pick a new pool address then walks the pool
// occupancy map one address per cycle, stopping at the first free address, at the
// end of the pool or at the end of the map, since 32 entries can never hold more
// than the first 32 pool addresses. A new command can be started in the cycle that
// out_valid is high. The user must write the configuration registers over the APB
// port only while busy is low; the block itself does not enforce it.
module lease_and_arp_table_engine_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lat_pkg::in_item_t   in_item,
  output logic                out_valid,
  output lat_pkg::out_item_t  out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import lat_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_POOL   = 4'b1000
  } state_t;

  cfg_t cfg;

  state_t             state_r;
  in_item_t           in_q_r;
  logic               rd_act_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic               dv_r;
  logic [IDX_W-1:0]   dv_idx_r;
  logic [1:0]         status_r [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] ip_vld_r;
  logic               has_r;
  logic [IDX_W-1:0]   prev_r;
  logic [IP_W-1:0]    prev_ip_r;
  logic [TABLE_ENTRIES-1:0] held_r;
  logic [TABLE_ENTRIES-1:0] bmp_r;
  logic               hit_r;
  logic [IDX_W-1:0]   hit_idx_r;
  logic [MAC_W-1:0]   hit_mac_r;
  logic [TIME_W-1:0]  hit_stamp_r;
  logic [PIDX_W-1:0]  pool_idx_r;
  logic               out_valid_r;
  out_item_t          out_item_r;

  // memory ports
  logic               ip_we;
  logic [IDX_W-1:0]   ip_waddr;
  logic [IP_W-1:0]    ip_wdata;
  logic [IP_W-1:0]    ip_rdata;
  logic               mb_we;
  logic [IDX_W-1:0]   mb_waddr;
  logic [MB_W-1:0]    mb_rdata;

  // scan view of the current entry
  logic [1:0]         st_rd;
  logic [IP_W-1:0]    ip_rd;
  logic [MAC_W-1:0]   mac_rd;
  logic [TIME_W-1:0]  stamp_rd;
  logic [IP_W-1:0]    pool_off;
  logic [TIME_W-1:0]  scan_age;
  logic               mac_eq;
  logic               last_dv;

  // decision signals
  logic               is_req;
  logic [1:0]         new_st;
  logic               in_range;
  logic               agreed;
  logic               match;
  logic [TABLE_ENTRIES-1:0] prev_mask;
  logic [IP_W:0]      cand;
  logic               cand_ok;
  logic [TIME_W-1:0]  res_age;
  logic               emit;
  logic               go_pool;
  out_item_t          res;
  logic               claim_en;
  logic [IP_W-1:0]    claim_ip;
  logic               claim_found;
  logic [IDX_W-1:0]   claim_k;
  logic               free_found;
  logic [IDX_W-1:0]   free_k;
  logic [IDX_W-1:0]   arp_slot;
  logic               sa_en;
  logic [IDX_W-1:0]   sa_idx;
  logic [1:0]         sa_val;
  logic               sb_en;

  lat_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lat_ram #(.W(IP_W), .D(TABLE_ENTRIES)) u_ip_ram (
    .clk   (clk),
    .we    (ip_we),
    .waddr (ip_waddr),
    .wdata (ip_wdata),
    .re    (rd_act_r),
    .raddr (rd_idx_r),
    .rdata (ip_rdata)
  );

  lat_ram #(.W(MB_W), .D(TABLE_ENTRIES)) u_mb_ram (
    .clk   (clk),
    .we    (mb_we),
    .waddr (mb_waddr),
    .wdata ({in_q_r.src_mac, in_q_r.now_us}),
    .re    (rd_act_r),
    .raddr (rd_idx_r),
    .rdata (mb_rdata)
  );

  // entry fields as seen in the cycle after the read
  assign st_rd    = status_r[dv_idx_r];
  assign ip_rd    = ip_vld_r[dv_idx_r] ? ip_rdata : '0;
  assign mac_rd   = mb_rdata[MB_W-1:TIME_W];
  assign stamp_rd = mb_rdata[TIME_W-1:0];
  assign pool_off = ip_rd - cfg.pool_start;
  assign scan_age = in_q_r.now_us - stamp_rd;
  assign mac_eq   = (st_rd != ST_FREE) && (mac_rd == in_q_r.src_mac);
  assign last_dv  = dv_r && (dv_idx_r == IDX_W'(TABLE_ENTRIES - 1));

  // lease decision terms
  assign is_req    = (in_q_r.cmd == CMD_REQUEST);
  assign new_st    = is_req ? ST_VALID : ST_RESERVED;
  assign match     = has_r && (prev_ip_r == in_q_r.ip_addr);
  assign prev_mask = has_r ? (TABLE_ENTRIES'(1) << prev_r) : '0;
  assign in_range  = (in_q_r.ip_addr >= cfg.pool_start) &&
                     ({1'b0, in_q_r.ip_addr} < ({1'b0, cfg.pool_start} +
                                                (IP_W + 1)'(cfg.eff_size)));
  assign agreed    = in_range && !(|(held_r & ~prev_mask));
  assign cand      = {1'b0, cfg.pool_start} + (IP_W + 1)'(pool_idx_r);
  assign cand_ok   = (EFF_W'(pool_idx_r) < cfg.eff_size) && !cand[IP_W];
  assign res_age   = in_q_r.now_us - hit_stamp_r;

  // lowest slot that is not valid (prev counts as freed) and lowest free slot
  always_comb begin
    claim_found = 1'b0;
    claim_k     = '0;
    free_found  = 1'b0;
    free_k      = '0;
    for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
      if (status_r[k] != ST_VALID || prev_mask[k]) begin
        claim_found = 1'b1;
        claim_k     = IDX_W'(k);
      end
      if (status_r[k] == ST_FREE) begin
        free_found = 1'b1;
        free_k     = IDX_W'(k);
      end
    end
  end

  assign arp_slot = hit_r ? hit_idx_r : free_k;

  // per-state actions and results
  always_comb begin
    emit     = 1'b0;
    go_pool  = 1'b0;
    res      = '0;
    claim_en = 1'b0;
    claim_ip = in_q_r.ip_addr;
    sa_en    = 1'b0;
    sa_idx   = prev_r;
    sa_val   = ST_FREE;
    sb_en    = 1'b0;
    ip_we    = 1'b0;
    ip_waddr = arp_slot;
    ip_wdata = in_q_r.ip_addr;
    mb_we    = 1'b0;
    mb_waddr = prev_r;
    unique case (state_r)
      S_IDLE: ;
      S_SCAN: begin
        if (dv_r) begin
          sa_idx = dv_idx_r;
          case (in_q_r.cmd)
            CMD_RELEASE: begin
              sa_en  = mac_eq;
              sa_val = ST_FREE;
            end
            CMD_AGE: begin
              sa_en  = (st_rd == ST_VALID) && ({1'b0, scan_age} > cfg.lim_full);
              sa_val = ST_STALE;
            end
            default: ;
          endcase
        end
      end
      S_DECIDE: begin
        emit = 1'b1;
        case (in_q_r.cmd) inside
          CMD_DISCOVER, CMD_REQUEST: begin
            if (match) begin
              sa_en  = 1'b1;
              sa_val = new_st;
              mb_we  = 1'b1;
              res.answer     = (is_req || agreed) ? ANS_GRANT : ANS_OFFER;
              res.offered_ip = in_q_r.ip_addr;
            end else if (has_r) begin
              if (agreed) begin
                sa_en    = 1'b1;
                sa_val   = ST_FREE;
                claim_en = 1'b1;
                res.answer     = ANS_GRANT;
                res.offered_ip = in_q_r.ip_addr;
              end else if (!is_req) begin
                sa_en  = 1'b1;
                sa_val = ST_RESERVED;
                res.answer     = ANS_OFFER;
                res.offered_ip = prev_ip_r;
              end
            end else if (agreed) begin
              claim_en = 1'b1;
              res.answer     = ANS_GRANT;
              res.offered_ip = in_q_r.ip_addr;
            end else if (!is_req) begin
              emit    = 1'b0;
              go_pool = 1'b1;
            end
          end
          CMD_ARP: begin
            if (!cfg.server_mode) begin
              res.flush_pending = 1'b1;
              if (in_q_r.target_addr == cfg.modem_address && (hit_r || free_found)) begin
                sa_en    = 1'b1;
                sa_idx   = arp_slot;
                sa_val   = ST_VALID;
                mb_we    = 1'b1;
                mb_waddr = arp_slot;
                ip_we    = !hit_r;
              end
            end
          end
          CMD_RESOLVE: begin
            if (cfg.server_mode) begin
              if (hit_r) begin
                res.answer       = ANS_GRANT;
                res.resolved_mac = hit_mac_r;
              end
            end else if (!hit_r) begin
              res.arp_query_needed = 1'b1;
            end else if ({1'b0, res_age} < cfg.lim_half) begin
              res.answer       = ANS_GRANT;
              res.resolved_mac = hit_mac_r;
            end else if ({1'b0, res_age} < cfg.lim_full) begin
              res.answer           = ANS_GRANT;
              res.resolved_mac     = hit_mac_r;
              res.arp_query_needed = 1'b1;
            end else begin
              res.arp_query_needed = 1'b1;
            end
          end
          default: ;
        endcase
      end
      S_POOL: begin
        // past the map every lower address is held, so this one is free
        if (!cand_ok) begin
          emit = 1'b1;
        end else if (pool_idx_r == PIDX_W'(TABLE_ENTRIES) ||
                     !bmp_r[pool_idx_r[IDX_W-1:0]]) begin
          emit     = 1'b1;
          claim_en = 1'b1;
          claim_ip = cand[IP_W-1:0];
          res.answer     = ANS_OFFER;
          res.offered_ip = cand[IP_W-1:0];
        end
      end
      default: ;
    endcase
    // new lease takes the lowest non-valid slot
    if (claim_en && claim_found) begin
      sb_en    = 1'b1;
      ip_we    = 1'b1;
      ip_waddr = claim_k;
      ip_wdata = claim_ip;
      mb_we    = 1'b1;
      mb_waddr = claim_k;
    end
  end

  // entry status and ip-written flags; a claim of the same slot wins
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < TABLE_ENTRIES; k++) begin
        status_r[k] <= ST_FREE;
      end
      ip_vld_r <= '0;
    end else begin
      if (sa_en && !(sb_en && sa_idx == claim_k)) begin
        status_r[sa_idx] <= sa_val;
      end
      if (sb_en) begin
        status_r[claim_k] <= new_st;
      end
      if (ip_we) begin
        ip_vld_r[ip_waddr] <= 1'b1;
      end
    end
  end

  // read sweep: address issue and data-valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_act_r <= 1'b0;
      rd_idx_r <= '0;
      dv_r     <= 1'b0;
      dv_idx_r <= '0;
    end else begin
      dv_r     <= rd_act_r;
      dv_idx_r <= rd_idx_r;
      if (state_r == S_IDLE && start) begin
        rd_act_r <= 1'b1;
        rd_idx_r <= '0;
      end else if (rd_act_r) begin
        rd_idx_r <= rd_idx_r + 1'b1;
        if (rd_idx_r == IDX_W'(TABLE_ENTRIES - 1)) begin
          rd_act_r <= 1'b0;
        end
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit;
      unique case (state_r)
        S_IDLE:   if (start) state_r <= S_SCAN;
        S_SCAN:   if (last_dv) state_r <= S_DECIDE;
        S_DECIDE: state_r <= go_pool ? S_POOL : S_IDLE;
        S_POOL:   if (emit) state_r <= S_IDLE;
        default:  state_r <= S_IDLE;
      endcase
    end
  end

  // result and command capture, scan accumulators and pool walk index
  always_ff @(posedge clk) begin
    if (emit) begin
      out_item_r <= res;
    end
    if (state_r == S_IDLE && start) begin
      in_q_r     <= in_item;
      has_r      <= 1'b0;
      hit_r      <= 1'b0;
      held_r     <= '0;
      bmp_r      <= '0;
    end else if (state_r == S_SCAN && dv_r) begin
      case (in_q_r.cmd) inside
        CMD_DISCOVER, CMD_REQUEST: begin
          if (mac_eq) begin
            has_r     <= 1'b1;
            prev_r    <= dv_idx_r;
            prev_ip_r <= ip_rd;
          end
          if (st_rd == ST_VALID && ip_rd == in_q_r.ip_addr) begin
            held_r[dv_idx_r] <= 1'b1;
          end
          // only the first table-size pool addresses need a map bit to find the lowest free one
          if (st_rd == ST_VALID && ip_rd >= cfg.pool_start &&
              pool_off < IP_W'(TABLE_ENTRIES)) begin
            bmp_r[pool_off[IDX_W-1:0]] <= 1'b1;
          end
        end
        CMD_ARP: begin
          if (ip_rd == in_q_r.ip_addr) begin
            hit_r     <= 1'b1;
            hit_idx_r <= dv_idx_r;
          end
        end
        CMD_RESOLVE: begin
          if ((st_rd == ST_VALID || (st_rd == ST_STALE && !cfg.server_mode)) &&
              ip_rd == in_q_r.ip_addr) begin
            hit_r       <= 1'b1;
            hit_idx_r   <= dv_idx_r;
            hit_mac_r   <= mac_rd;
            hit_stamp_r <= stamp_rd;
          end
        end
        default: ;
      endcase
    end
    if (state_r == S_DECIDE) begin
      pool_idx_r <= '0;
    end else if (state_r == S_POOL) begin
      pool_idx_r <= pool_idx_r + 1'b1;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== hdl/lat_chk.sv =====
module lat_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input lat_pkg::out_item_t out_item
);
  import lat_pkg::*;

  // an accepted command holds the engine
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("command accepted but busy not raised");

  // a result only ends a command in progress
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) && !busy))
    else $error("result strobe without a command finishing");

  // one result per command
  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // answer code range
  a_answer_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.answer == ANS_NONE || out_item.answer == ANS_GRANT ||
                   out_item.answer == ANS_OFFER))
    else $error("answer code out of range");

endmodule

bind lease_and_arp_table_engine_top lat_chk u_lat_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

// ===== dv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lat_pkg::*;

  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_ITEMS    = 150;
  localparam int PHASES         = 7;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_valid;
  out_item_t   out_item;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lease_and_arp_table_engine_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // shadow copy of the lease table and the registers
  logic [1:0]        tbl_status [TABLE_ENTRIES];
  logic [IP_W-1:0]   tbl_ip     [TABLE_ENTRIES];
  logic [MAC_W-1:0]  tbl_mac    [TABLE_ENTRIES];
  logic [TIME_W-1:0] tbl_stamp  [TABLE_ENTRIES];

  logic [IP_W-1:0]    cfg_pool_start;
  logic [PSIZE_W-1:0] cfg_pool_size;
  logic [IP_W-1:0]    cfg_modem;
  logic [TOUT_W-1:0]  cfg_timeout;
  logic               cfg_server;

  out_item_t         lease_q[$];
  int                fail_cnt;
  int                quiet_cycles;
  bit                idle_en;
  logic [TIME_W-1:0] now_cur;
  logic [MAC_W-1:0]  mac_set [6];

  always #10 clk = ~clk;

  // ---------------- lease table predictor ----------------
  function automatic int last_by_mac(logic [MAC_W-1:0] mac);
    int hit;
    hit = -1;
    for (int k = 0; k < TABLE_ENTRIES; k++)
      if (tbl_status[k] != ST_FREE && tbl_mac[k] == mac) hit = k;
    return hit;
  endfunction

  function automatic bit ip_taken(logic [IP_W-1:0] ip, int skip);
    for (int k = 0; k < TABLE_ENTRIES; k++)
      if (k != skip && tbl_status[k] == ST_VALID && tbl_ip[k] == ip) return 1;
    return 0;
  endfunction

  function automatic void set_status(int k, logic [1:0] st, logic [TIME_W-1:0] now);
    tbl_status[k] = st;
    if (st == ST_VALID) tbl_stamp[k] = now;
  endfunction

  function automatic out_item_t lease_decision(bit is_req, logic [MAC_W-1:0] mac,
                                               logic [IP_W-1:0] req, logic [TIME_W-1:0] now);
    out_item_t  o;
    logic [1:0] new_st;
    int         prev;
    bit         has, match, claim, in_range, agreed;
    logic [32:0] size, cand;
    o = '0;
    new_st = is_req ? ST_VALID : ST_RESERVED;
    prev = last_by_mac(mac);
    has = prev >= 0;
    match = has && tbl_ip[prev] == req;
    claim = 0;
    size = (cfg_pool_size > MAX_POOL) ? 33'(MAX_POOL) : 33'(cfg_pool_size);
    if (match) begin
      o.answer = ANS_GRANT;
      o.offered_ip = req;
      set_status(prev, new_st, now);
    end
    in_range = req >= cfg_pool_start && {1'b0, req} < {1'b0, cfg_pool_start} + size;
    agreed = in_range && !ip_taken(req, prev);
    if (has && !match && agreed) tbl_status[prev] = ST_FREE;
    if (!is_req && !agreed) begin
      if (!has) begin
        for (int i = 0; i < size; i++) begin
          cand = {1'b0, cfg_pool_start} + 33'(i);
          if (cand[32]) break;
          if (!ip_taken(cand[31:0], -1)) begin
            o.offered_ip = cand[31:0];
            o.answer = ANS_OFFER;
            claim = 1;
            break;
          end
        end
      end else begin
        o.offered_ip = tbl_ip[prev];
        tbl_status[prev] = ST_RESERVED;
        o.answer = ANS_OFFER;
      end
    end
    if (agreed) begin
      o.offered_ip = req;
      o.answer = ANS_GRANT;
      if (match) set_status(prev, new_st, now);
      else claim = 1;
    end
    if (claim) begin
      for (int k = 0; k < TABLE_ENTRIES; k++)
        if (tbl_status[k] != ST_VALID) begin
          set_status(k, new_st, now);
          tbl_ip[k] = o.offered_ip;
          tbl_mac[k] = mac;
          break;
        end
    end
    return o;
  endfunction

  function automatic void learn_arp(in_item_t it);
    int hit;
    hit = -1;
    if (it.target_addr != cfg_modem) return;
    for (int k = 0; k < TABLE_ENTRIES; k++)
      if (tbl_ip[k] == it.ip_addr) hit = k;
    if (hit < 0) begin
      for (int k = 0; k < TABLE_ENTRIES; k++)
        if (tbl_status[k] == ST_FREE) begin
          hit = k;
          break;
        end
      if (hit < 0) return;
      tbl_ip[hit] = it.ip_addr;
    end
    tbl_mac[hit] = it.src_mac;
    set_status(hit, ST_VALID, it.now_us);
  endfunction

  function automatic out_item_t resolve_addr(in_item_t it);
    out_item_t         o;
    int                hit;
    bit                live;
    logic [TIME_W-1:0] age;
    o = '0;
    hit = -1;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      live = cfg_server ? tbl_status[k] == ST_VALID
                        : (tbl_status[k] == ST_VALID || tbl_status[k] == ST_STALE);
      if (live && tbl_ip[k] == it.ip_addr) hit = k;
    end
    if (cfg_server) begin
      if (hit >= 0) begin
        o.answer = ANS_GRANT;
        o.resolved_mac = tbl_mac[hit];
      end
      return o;
    end
    if (hit < 0) begin
      o.arp_query_needed = 1'b1;
      return o;
    end
    age = (it.now_us - tbl_stamp[hit]) / 32'd1000000;
    if (age < 32'(cfg_timeout / 2)) begin
      o.answer = ANS_GRANT;
      o.resolved_mac = tbl_mac[hit];
    end else if (age < 32'(cfg_timeout)) begin
      o.answer = ANS_GRANT;
      o.resolved_mac = tbl_mac[hit];
      o.arp_query_needed = 1'b1;
    end else begin
      o.arp_query_needed = 1'b1;
    end
    return o;
  endfunction

  function automatic out_item_t predict_lease_result(in_item_t it);
    out_item_t         o;
    logic [63:0]       limit;
    logic [TIME_W-1:0] age;
    o = '0;
    case (it.cmd)
      CMD_DISCOVER: o = lease_decision(0, it.src_mac, it.ip_addr, it.now_us);
      CMD_REQUEST:  o = lease_decision(1, it.src_mac, it.ip_addr, it.now_us);
      CMD_RELEASE: begin
        for (int k = 0; k < TABLE_ENTRIES; k++)
          if (tbl_status[k] != ST_FREE && tbl_mac[k] == it.src_mac)
            tbl_status[k] = ST_FREE;
      end
      CMD_ARP: begin
        if (!cfg_server) begin
          learn_arp(it);
          o.flush_pending = 1'b1;
        end
      end
      CMD_AGE: begin
        limit = 64'd1000000 * 64'(cfg_timeout);
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
          age = it.now_us - tbl_stamp[k];
          if (tbl_status[k] == ST_VALID && 64'(age) > limit) tbl_status[k] = ST_STALE;
        end
      end
      CMD_RESOLVE: o = resolve_addr(it);
      default: ;
    endcase
    return o;
  endfunction

  // ---------------- result checker ----------------
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid) begin
      if (lease_q.size() == 0) begin
        $error("unexpected result transfer");
        fail_cnt++;
      end else begin
        exp_r = lease_q.pop_front();
        if (out_item.answer !== exp_r.answer) begin
          $error("answer exp %0d got %0d", exp_r.answer, out_item.answer);
          fail_cnt++;
        end
        if (out_item.offered_ip !== exp_r.offered_ip) begin
          $error("offered_ip exp %h got %h", exp_r.offered_ip, out_item.offered_ip);
          fail_cnt++;
        end
        if (out_item.resolved_mac !== exp_r.resolved_mac) begin
          $error("resolved_mac exp %h got %h", exp_r.resolved_mac, out_item.resolved_mac);
          fail_cnt++;
        end
        if (out_item.arp_query_needed !== exp_r.arp_query_needed) begin
          $error("arp_query_needed exp %0d got %0d", exp_r.arp_query_needed,
                 out_item.arp_query_needed);
          fail_cnt++;
        end
        if (out_item.flush_pending !== exp_r.flush_pending) begin
          $error("flush_pending exp %0d got %0d", exp_r.flush_pending, out_item.flush_pending);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // ---------------- drivers ----------------
  // one command transfer; returns at the falling edge after acceptance, start still high
  task automatic send_cmd(in_item_t it);
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    lease_q.push_back(predict_lease_result(it));
    @(negedge clk);
  endtask

  task automatic pause(int n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // let the engine finish everything in flight
  task automatic drain();
    start <= 1'b0;
    while (lease_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_POOL_START: cfg_pool_start = value;
      REG_POOL_SIZE:  cfg_pool_size = value[PSIZE_W-1:0];
      REG_MODEM:      cfg_modem = value;
      REG_TIMEOUT:    cfg_timeout = value[TOUT_W-1:0];
      REG_SERVER:     cfg_server = value[0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(logic [31:0] pstart, logic [31:0] psize, logic [31:0] modem,
                           logic [31:0] tout, logic [31:0] server);
    drain();
    reg_write(REG_POOL_START, pstart);
    reg_write(REG_POOL_SIZE, psize);
    reg_write(REG_MODEM, modem);
    reg_write(REG_TIMEOUT, tout);
    reg_write(REG_SERVER, server);
  endtask

  function automatic in_item_t mk(logic [2:0] cmd, logic [MAC_W-1:0] mac, logic [IP_W-1:0] ip,
                                  logic [IP_W-1:0] tgt, logic [TIME_W-1:0] now);
    in_item_t it;
    it.cmd = cmd;
    it.src_mac = mac;
    it.ip_addr = ip;
    it.target_addr = tgt;
    it.now_us = now;
    return it;
  endfunction

  // ---------------- tests ----------------
  // defaults after reset: empty pool, modem address zero, ARP cache mode
  task automatic test_reset_defaults();
    send_cmd(mk(CMD_DISCOVER, 48'h0, 32'h0, 32'h0, 32'd100));
    send_cmd(mk(CMD_RESOLVE, 48'h0, 32'hFFFF_FFFF, 32'h0, 32'd200));
    send_cmd(mk(CMD_ARP, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF));
    send_cmd(mk(CMD_RESOLVE, 48'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1000));
    send_cmd(mk(CMD_SPARE_LO, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd5));
    send_cmd(mk(CMD_SPARE_HI, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd6));
  endtask

  // offer, grant, conflict, move, release, ARP learn
  task automatic test_lease_flow();
    configure(32'h0A00_0064, 4, 32'h0A00_0001, 360, 0);
    send_cmd(mk(CMD_DISCOVER, 48'h0000_0000_00A1, 32'h0, 32'h0, 32'd1000));
    send_cmd(mk(CMD_REQUEST, 48'h0000_0000_00A1, 32'h0A00_0064, 32'h0, 32'd2000));
    send_cmd(mk(CMD_DISCOVER, 48'h0000_0000_00B2, 32'h0A00_0064, 32'h0, 32'd3000));
    send_cmd(mk(CMD_REQUEST, 48'h0000_0000_00B2, 32'h0A00_0067, 32'h0, 32'd4000));
    send_cmd(mk(CMD_REQUEST, 48'h0000_0000_00C3, 32'h0505_0505, 32'h0, 32'd5000));
    send_cmd(mk(CMD_RELEASE, 48'h0000_0000_00A1, 32'h0, 32'h0, 32'd6000));
    send_cmd(mk(CMD_RESOLVE, 48'h0, 32'h0A00_0064, 32'h0, 32'd7000));
    send_cmd(mk(CMD_ARP, 48'h1234_5678_9ABC, 32'h0A00_0007, 32'h0A00_0001, 32'd8000));
    send_cmd(mk(CMD_ARP, 48'h1111_2222_3333, 32'h0A00_0008, 32'h0A00_0099, 32'd9000));
    send_cmd(mk(CMD_RESOLVE, 48'h0, 32'h0A00_0007, 32'h0, 32'd10000));
  endtask

  // pool at the top of the address space, oversized pool, own lease out of range
  task automatic test_pool_edges();
    configure(32'hFFFF_FFFE, 300, 32'h0A00_0001, 360, 0);
    send_cmd(mk(CMD_DISCOVER, 48'h0000_0000_00D4, 32'h0, 32'h0, 32'd1000));
    send_cmd(mk(CMD_REQUEST, 48'h0000_0000_00D4, 32'hFFFF_FFFF, 32'h0, 32'd2000));
    send_cmd(mk(CMD_DISCOVER, 48'h0000_0000_00E5, 32'h0, 32'h0, 32'd3000));
    configure(32'h0, 511, 32'h0A00_0001, 360, 0);
    send_cmd(mk(CMD_REQUEST, 48'h0000_0000_00D4, 32'hFFFF_FFFF, 32'h0, 32'd4000));
  endtask

  // zero timeout ages everything, the longest one never does
  task automatic test_aging();
    configure(32'h0A00_0064, 4, 32'h0A00_0001, 0, 0);
    send_cmd(mk(CMD_AGE, 48'h0, 32'h0, 32'h0, 32'd4001));
    send_cmd(mk(CMD_RESOLVE, 48'h0, 32'h0A00_0007, 32'h0, 32'd4002));
    configure(32'h0A00_0064, 4, 32'h0A00_0001, 8191, 0);
    send_cmd(mk(CMD_ARP, 48'hABCD_EF01_2345, 32'h0A00_0009, 32'h0A00_0001, 32'd0));
    send_cmd(mk(CMD_AGE, 48'h0, 32'h0, 32'h0, 32'hFFFF_FFFF));
    send_cmd(mk(CMD_RESOLVE, 48'h0, 32'h0A00_0009, 32'h0, 32'hF000_0000));
  endtask

  // server mode: ARP replies dropped, only valid leases resolve
  task automatic test_server_mode();
    configure(32'h0A00_0064, 4, 32'h0A00_0001, 360, 1);
    send_cmd(mk(CMD_ARP, 48'h5555_5555_5555, 32'h0A00_000A, 32'h0A00_0001, 32'd10));
    send_cmd(mk(CMD_RESOLVE, 48'h0, 32'h0A00_0009, 32'h0, 32'd20));
    send_cmd(mk(CMD_RESOLVE, 48'h0, 32'h0A00_000A, 32'h0, 32'd30));
  endtask

  function automatic in_item_t rand_item();
    in_item_t it;
    int       sel;
    logic [32:0] span;
    sel = $urandom_range(0, 99);
    if (sel < 25) it.cmd = CMD_DISCOVER;
    else if (sel < 50) it.cmd = CMD_REQUEST;
    else if (sel < 58) it.cmd = CMD_RELEASE;
    else if (sel < 73) it.cmd = CMD_ARP;
    else if (sel < 83) it.cmd = CMD_AGE;
    else if (sel < 98) it.cmd = CMD_RESOLVE;
    else it.cmd = ($urandom_range(0, 1) != 0) ? CMD_SPARE_HI : CMD_SPARE_LO;
    if ($urandom_range(0, 9) == 0) it.src_mac = MAC_W'({$urandom, $urandom});
    else it.src_mac = mac_set[$urandom_range(0, 5)];
    span = 33'(cfg_pool_size) + 33'd2;
    sel = $urandom_range(0, 9);
    if (sel < 7) it.ip_addr = cfg_pool_start + 32'($urandom_range(0, int'(span)));
    else if (sel < 8) it.ip_addr = cfg_modem;
    else it.ip_addr = $urandom;
    it.target_addr = ($urandom_range(0, 3) != 0) ? cfg_modem : $urandom;
    if ($urandom_range(0, 19) == 0) now_cur = $urandom;
    else now_cur = now_cur + 32'($urandom_range(0, 3_000_000));
    it.now_us = now_cur;
    return it;
  endfunction

  // random traffic over several register settings, no idling in the last phase
  task automatic test_random_traffic();
    logic [31:0] pstart, psize, tout;
    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 3))
        0: pstart = 32'h0;
        1: pstart = 32'hFFFF_FF00 + 32'($urandom_range(0, 255));
        default: pstart = $urandom;
      endcase
      case ($urandom_range(0, 4))
        0: psize = 0;
        1: psize = 256;
        2: psize = $urandom_range(257, 511);
        default: psize = $urandom_range(1, 40);
      endcase
      case ($urandom_range(0, 5))
        0: tout = 0;
        1: tout = 8191;
        2: tout = 4294;
        default: tout = $urandom_range(1, 20);
      endcase
      configure(pstart, psize, $urandom, tout, 32'($urandom_range(0, 4) == 0));
      idle_en = (p != PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (idle_en && $urandom_range(0, 3) == 0) pause($urandom_range(1, 13));
        send_cmd(rand_item());
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    fail_cnt = 0;
    quiet_cycles = 0;
    idle_en = 1'b1;
    now_cur = $urandom;
    cfg_pool_start = '0;
    cfg_pool_size = '0;
    cfg_modem = '0;
    cfg_timeout = DEFAULT_TIMEOUT;
    cfg_server = 1'b0;
    for (int k = 0; k < TABLE_ENTRIES; k++) begin
      tbl_status[k] = ST_FREE;
      tbl_ip[k] = '0;
      tbl_mac[k] = '0;
      tbl_stamp[k] = '0;
    end
    mac_set[0] = 48'h0;
    mac_set[1] = 48'hFFFF_FFFF_FFFF;
    for (int i = 2; i < 6; i++) mac_set[i] = MAC_W'({$urandom, $urandom});
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_lease_flow();
    test_pool_edges();
    test_aging();
    test_server_mode();
    test_random_traffic();

    drain();
    repeat (320) @(negedge clk);
    if (fail_cnt == 0 && lease_q.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
